/* src/sstf_pkg.sv */
package sstf_pkg;

  localparam int CYL_FIELD_W  = 16;
  localparam int DIST_FIELD_W = 16;
  localparam int TOTAL_W      = 23;
  localparam int TOTAL_OUT_W  = 22;
  localparam int HEAD_CFG_W   = 16;

  typedef struct packed {
    logic [CYL_FIELD_W-1:0] request_cylinder;
    logic                   last_request;
  } in_word_t;

  typedef struct packed {
    logic [CYL_FIELD_W-1:0]  served_cylinder;
    logic [DIST_FIELD_W-1:0] seek_distance;
    logic [TOTAL_OUT_W-1:0]  running_total;
    logic                    batch_done;
    logic                    dropped;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

/* src/sstf_ram.sv */
module sstf_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sstf_disk_request_scheduler_core.sv */
// Load: one request word is taken per cycle while the batch is being collected.
// Scheduling: for each served request the scan reads all N stored requests from the
// request memory, one entry per cycle, through a two-stage distance/compare pipeline,
// and the scan starts over from the first entry after every emitted word.
// Reset (rst_n, synchronous, active low) empties the batch, clears the served flags
// and sets the initial head to zero; the request memory itself is not cleared.
module sstf_disk_request_scheduler_core #(
  parameter int MAX_REQUESTS = 64,
  parameter int CYL_BITS     = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sstf_pkg::in_word_t                     in_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output sstf_pkg::out_word_t                    out_word,
  input  logic                                   cfg_wr_en,
  input  logic [sstf_pkg::HEAD_CFG_W-1:0]        cfg_wr_data
);

  localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CylW    = CYL_BITS;
  localparam int TotW    = sstf_pkg::TOTAL_W;
  localparam int TotOutW = sstf_pkg::TOTAL_OUT_W;
  localparam int DistW   = sstf_pkg::DIST_FIELD_W;
  localparam int CylOutW = sstf_pkg::CYL_FIELD_W;

  sstf_pkg::state_t state_r, state_nxt;

  logic [sstf_pkg::HEAD_CFG_W-1:0] init_head_r, init_head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        picks_r, picks_nxt;
  logic [CNT_W-1:0]        rd_addr_r, rd_addr_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;
  logic [CylW-1:0]         head_r, head_nxt;
  logic [TotW-1:0]         total_r, total_nxt;

  logic                    s1_v_r, s1_v_nxt;
  logic [IDX_W-1:0]        s1_idx_r, s1_idx_nxt;
  logic                    s2_v_r, s2_v_nxt;
  logic [IDX_W-1:0]        s2_idx_r, s2_idx_nxt;
  logic [CylW-1:0]         s2_d_r, s2_d_nxt;
  logic [CylW-1:0]         s2_cyl_r, s2_cyl_nxt;

  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [CylW-1:0]         best_d_r, best_d_nxt;
  logic [CylW-1:0]         best_cyl_r, best_cyl_nxt;

  logic                    out_valid_r, out_valid_nxt;
  sstf_pkg::out_word_t     out_word_r, out_word_nxt;

  logic                    ram_we;
  logic                    ram_re;
  logic [CylW-1:0]         ram_wdata;
  logic [CylW-1:0]         ram_rdata;
  logic [CylW-1:0]         seek_d;
  logic [TotW-1:0]         total_sum;
  logic                    last_pick;
  logic                    emit_fire;

  // The memory is written only while loading and read only while scanning,
  // so the state machine itself keeps the two access kinds apart.
  sstf_ram #(
    .WIDTH (CylW),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_addr_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign ram_wdata = CylW'(in_word.request_cylinder);
  assign seek_d    = (ram_rdata >= head_r) ? (ram_rdata - head_r) : (head_r - ram_rdata);
  assign total_sum = total_r + TotW'(best_d_r);
  assign last_pick = ((picks_r + CNT_W'(1)) == count_r);
  assign emit_fire = (state_r == sstf_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    init_head_nxt = init_head_r;
    count_nxt     = count_r;
    picks_nxt     = picks_r;
    rd_addr_nxt   = rd_addr_r;
    ovf_nxt       = ovf_r;
    served_nxt    = served_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    best_cyl_nxt  = best_cyl_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (cfg_wr_en) begin
      init_head_nxt = cfg_wr_data;
    end

    // Entries already served drop out of the pipeline before the compare.
    s1_v_nxt   = 1'b0;
    s1_idx_nxt = rd_addr_r[IDX_W-1:0];
    s2_v_nxt   = s1_v_r && !served_r[s1_idx_r];
    s2_idx_nxt = s1_idx_r;
    s2_d_nxt   = seek_d;
    s2_cyl_nxt = ram_rdata;

    // A strict compare keeps the earliest loaded entry on a tie.
    if (s2_v_r && (!found_r || (s2_d_r < best_d_r))) begin
      found_nxt    = 1'b1;
      best_idx_nxt = s2_idx_r;
      best_d_nxt   = s2_d_r;
      best_cyl_nxt = s2_cyl_r;
    end

    case (state_r)
      sstf_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_REQUESTS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_word.last_request) begin
            head_nxt    = CylW'(init_head_r);
            rd_addr_nxt = '0;
            picks_nxt   = '0;
            found_nxt   = 1'b0;
            state_nxt   = sstf_pkg::ST_SCAN;
          end
        end
      end
      sstf_pkg::ST_SCAN: begin
        if (rd_addr_r < count_r) begin
          ram_re      = 1'b1;
          s1_v_nxt    = 1'b1;
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end else if (!s1_v_r && !s2_v_r) begin
          state_nxt = sstf_pkg::ST_EMIT;
        end
      end
      sstf_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.served_cylinder = CylOutW'(best_cyl_r);
          out_word_nxt.seek_distance   = DistW'(best_d_r);
          out_word_nxt.running_total   = TotOutW'(total_sum);
          out_word_nxt.batch_done      = last_pick;
          out_word_nxt.dropped         = ovf_r;
          served_nxt[best_idx_r]       = 1'b1;
          head_nxt                     = best_cyl_r;
          picks_nxt                    = picks_r + CNT_W'(1);
          rd_addr_nxt                  = '0;
          found_nxt                    = 1'b0;
          if (last_pick) begin
            count_nxt  = '0;
            picks_nxt  = '0;
            served_nxt = '0;
            total_nxt  = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = sstf_pkg::ST_LOAD;
          end else begin
            total_nxt = total_sum;
            state_nxt = sstf_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = sstf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sstf_pkg::ST_LOAD;
      init_head_r <= '0;
      count_r     <= '0;
      picks_r     <= '0;
      rd_addr_r   <= '0;
      ovf_r       <= 1'b0;
      served_r    <= '0;
      head_r      <= '0;
      total_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_head_r <= init_head_nxt;
      count_r     <= count_nxt;
      picks_r     <= picks_nxt;
      rd_addr_r   <= rd_addr_nxt;
      ovf_r       <= ovf_nxt;
      served_r    <= served_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= s1_idx_nxt;
    s2_idx_r   <= s2_idx_nxt;
    s2_d_r     <= s2_d_nxt;
    s2_cyl_r   <= s2_cyl_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    best_cyl_r <= best_cyl_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != sstf_pkg::ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Every served flag set so far corresponds to one word already produced.
  a_flags_match_picks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(served_r) == picks_r)
    else $error("served flag count differs from pick count");

  // A scan only ever starts with at least one stored request.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sstf_pkg::ST_SCAN) |-> (count_r != '0))
    else $error("scan entered with an empty batch");

  // After the final word of a batch everything is ready for a fresh batch.
  a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && last_pick) |=>
      (count_r == '0 && served_r == '0 && !ovf_r && total_r == '0
       && state_r == sstf_pkg::ST_LOAD))
    else $error("batch state not cleared after the final pick");

  // The head follows the cylinder just served.
  a_head_follows: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (head_r == $past(best_cyl_r) && out_valid_r))
    else $error("head position not updated to the served cylinder");

endmodule
